/* rtl/core/ffd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field decoder package
// Shared payload types, configuration indexes and character constants.
// ----------------------------------------------------------------------------
package ffd_pkg;

    localparam int MAX_KEY_LEN   = 8;
    localparam int MAX_VALUE_LEN = 127;
    localparam int BUNDLE_SLOTS  = 3;

    typedef enum logic [1:0] {
        CFG_KEY_TEXT      = 2'd0,
        CFG_KEY_LENGTH    = 2'd1,
        CFG_MAX_VALUE_LEN = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_body;
    } ffd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       found;
        logic       last;
    } ffd_out_t;

    typedef struct packed {
        logic [BUNDLE_SLOTS-1:0][7:0] data;
        logic [1:0]                   n_data;
        logic                         has_status;
        logic                         found;
    } ffd_bundle_t;

endpackage

/* rtl/core/ffd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field decoder front end
// Accepts body bytes, tracks key matching and escape decoding, applies the
// value capacity and hands the results of each byte on as one bundle.
// ----------------------------------------------------------------------------
module ffd_front
    import ffd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ffd_in_t     in_data,
    input  logic        cfg_valid,
    input  cfg_index_t  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        push,
    output ffd_bundle_t bundle,
    input  logic        q_full
);

    typedef enum logic [3:0] {
        PH_MATCH = 4'b0001,
        PH_SKIP  = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    logic [63:0] key_text_reg;
    logic [3:0]  key_length_reg;
    logic [6:0]  max_value_len_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  key_pos_reg, key_pos_next;
    logic        key_match_reg, key_match_next;
    logic [1:0]  esc_cnt_reg, esc_cnt_next;
    logic [7:0]  esc_byte_reg, esc_byte_next;
    logic [6:0]  emitted_reg, emitted_next;

    logic                         accept;
    logic [7:0]                   b;
    logic [3:0]                   klen;
    logic [7:0]                   key_char;
    logic [4:0]                   hex_hi, hex_lo;
    logic [BUNDLE_SLOTS-1:0][7:0] cand;
    logic [1:0]                   nc;
    logic                         flush_now;
    logic                         found_now;
    logic [7:0]                   cap;
    logic [7:0]                   room;
    logic [1:0]                   keep;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.in_byte;
    assign klen     = (key_length_reg > 4'(MAX_KEY_LEN)) ? 4'(MAX_KEY_LEN) : key_length_reg;
    assign key_char = key_text_reg[{key_pos_reg[2:0], 3'b000} +: 8];
    assign hex_hi   = hex_digit(esc_byte_reg);
    assign hex_lo   = hex_digit(b);

    always_comb
    begin
        phase_next     = phase_reg;
        key_pos_next   = key_pos_reg;
        key_match_next = key_match_reg;
        esc_cnt_next   = esc_cnt_reg;
        esc_byte_next  = esc_byte_reg;
        emitted_next   = emitted_reg;
        cand           = '0;
        nc             = 2'd0;
        flush_now      = 1'b0;
        found_now      = 1'b0;
        cap            = 8'd0;
        room           = 8'd0;
        keep           = 2'd0;

        unique case (phase_reg)
            PH_MATCH:
            begin
                if (b == CHAR_AMP)
                begin
                    key_pos_next   = 4'd0;
                    key_match_next = 1'b1;
                end
                else if (b == CHAR_EQ)
                begin
                    if (key_match_reg && key_pos_reg == klen)
                    begin
                        phase_next   = PH_VALUE;
                        esc_cnt_next = 2'd0;
                        emitted_next = 7'd0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else if (key_match_reg && key_pos_reg < klen && b == key_char)
                begin
                    key_pos_next = key_pos_reg + 4'd1;
                end
                else
                begin
                    key_match_next = 1'b0;
                end
            end
            PH_SKIP:
            begin
                if (b == CHAR_AMP)
                begin
                    phase_next     = PH_MATCH;
                    key_pos_next   = 4'd0;
                    key_match_next = 1'b1;
                end
            end
            PH_VALUE:
            begin
                if (b == CHAR_AMP)
                begin
                    flush_now  = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (esc_cnt_reg == 2'd2)
                begin
                    esc_cnt_next = 2'd0;
                    if (hex_hi[4] && hex_lo[4])
                    begin
                        cand[nc] = {hex_hi[3:0], hex_lo[3:0]};
                        nc       = nc + 2'd1;
                    end
                    else
                    begin
                        cand[nc] = CHAR_PCT;
                        nc       = nc + 2'd1;
                        if (esc_byte_reg == CHAR_PLUS)
                        begin
                            cand[nc] = CHAR_SPACE;
                            nc       = nc + 2'd1;
                        end
                        else if (esc_byte_reg == CHAR_PCT)
                        begin
                            esc_cnt_next = 2'd1;
                        end
                        else
                        begin
                            cand[nc] = esc_byte_reg;
                            nc       = nc + 2'd1;
                        end
                        if (esc_cnt_next == 2'd1)
                        begin
                            esc_byte_next = b;
                            esc_cnt_next  = 2'd2;
                        end
                        else if (b == CHAR_PLUS)
                        begin
                            cand[nc] = CHAR_SPACE;
                            nc       = nc + 2'd1;
                        end
                        else if (b == CHAR_PCT)
                        begin
                            esc_cnt_next = 2'd1;
                        end
                        else
                        begin
                            cand[nc] = b;
                            nc       = nc + 2'd1;
                        end
                    end
                end
                else if (esc_cnt_reg == 2'd1)
                begin
                    esc_byte_next = b;
                    esc_cnt_next  = 2'd2;
                end
                else if (b == CHAR_PLUS)
                begin
                    cand[nc] = CHAR_SPACE;
                    nc       = nc + 2'd1;
                end
                else if (b == CHAR_PCT)
                begin
                    esc_cnt_next = 2'd1;
                end
                else
                begin
                    cand[nc] = b;
                    nc       = nc + 2'd1;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_MATCH;
            end
        endcase

        if (in_data.end_of_body)
        begin
            found_now = (phase_next == PH_VALUE) || (phase_next == PH_DONE);
            if (phase_next == PH_VALUE)
            begin
                flush_now = 1'b1;
            end
        end

        if (flush_now)
        begin
            if (esc_cnt_next != 2'd0)
            begin
                cand[nc] = CHAR_PCT;
                nc       = nc + 2'd1;
            end
            if (esc_cnt_next == 2'd2)
            begin
                cand[nc] = (esc_byte_next == CHAR_PLUS) ? CHAR_SPACE : esc_byte_next;
                nc       = nc + 2'd1;
            end
            esc_cnt_next = 2'd0;
        end

        cap  = ({1'b0, max_value_len_reg} < 8'(MAX_VALUE_LEN)) ?
               {1'b0, max_value_len_reg} : 8'(MAX_VALUE_LEN);
        room = ({1'b0, emitted_next} < cap) ? (cap - {1'b0, emitted_next}) : 8'd0;
        keep = (room < {6'd0, nc}) ? room[1:0] : nc;
        emitted_next = emitted_next + {5'd0, keep};

        if (in_data.end_of_body)
        begin
            phase_next     = PH_MATCH;
            key_pos_next   = 4'd0;
            key_match_next = 1'b1;
            esc_cnt_next   = 2'd0;
            emitted_next   = 7'd0;
        end
    end

    assign bundle.data       = cand;
    assign bundle.n_data     = keep;
    assign bundle.has_status = in_data.end_of_body;
    assign bundle.found      = found_now;
    assign push              = accept && (keep != 2'd0 || in_data.end_of_body);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg      <= 64'd0;
            key_length_reg    <= 4'd1;
            max_value_len_reg <= 7'd23;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_TEXT:      key_text_reg      <= cfg_data;
                CFG_KEY_LENGTH:    key_length_reg    <= cfg_data[3:0];
                CFG_MAX_VALUE_LEN: max_value_len_reg <= cfg_data[6:0];
                CFG_UNUSED:        key_length_reg    <= key_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MATCH;
            key_pos_reg   <= 4'd0;
            key_match_reg <= 1'b1;
            esc_cnt_reg   <= 2'd0;
            emitted_reg   <= 7'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            key_pos_reg   <= key_pos_next;
            key_match_reg <= key_match_next;
            esc_cnt_reg   <= esc_cnt_next;
            emitted_reg   <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            esc_byte_reg <= esc_byte_next;
        end
    end

endmodule

/* rtl/core/ffd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field decoder bundle queue
// Small register FIFO that decouples the front end from the output side.
// ----------------------------------------------------------------------------
module ffd_queue
    import ffd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ffd_bundle_t wdata,
    output logic        full,
    input  logic        pop,
    output ffd_bundle_t rdata,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ffd_bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/ffd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field decoder output side
// Unpacks queued bundles into single results behind an output register.
// ----------------------------------------------------------------------------
module ffd_back
    import ffd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ffd_bundle_t head,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output ffd_out_t    out_data
);

    logic [1:0] sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;
    ffd_out_t   out_data_reg, out_data_next;
    logic       load;
    logic [2:0] total;
    logic       last_entry;

    assign total      = {1'b0, head.n_data} + {2'b00, head.has_status};
    assign last_entry = ({1'b0, sel_reg} + 3'd1) == total;
    assign load       = !q_empty && (!out_valid_reg || out_ready);
    assign pop        = load && last_entry;

    always_comb
    begin
        sel_next       = sel_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            sel_next       = last_entry ? 2'd0 : sel_reg + 2'd1;
            if (sel_reg < head.n_data)
            begin
                out_data_next.out_byte = head.data[sel_reg];
                out_data_next.is_data  = 1'b1;
                out_data_next.found    = 1'b0;
                out_data_next.last     = 1'b0;
            end
            else
            begin
                out_data_next.out_byte = 8'd0;
                out_data_next.is_data  = 1'b0;
                out_data_next.found    = head.found;
                out_data_next.last     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/form_field_extract_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field extract and decode
// Extracts and URL-decodes the value of one configured key from a form body.
// ----------------------------------------------------------------------------
// The block takes one body byte per cycle whenever its bundle queue has room;
// the front end works out all results of a byte in that cycle. The output
// register hands out one result per cycle while out_ready is high, so a
// byte that yields one result or none keeps a rate of one byte per cycle,
// while a byte that yields several results, up to four (a broken or cut
// escape, the status at the end of a body), is absorbed by the queue's QUEUE_DEPTH bundles.
// The first result of a byte is written into the queue and then into the
// output register before it is presented. Write the key and capacity
// registers only while the block is idle.
module form_field_extract_decode
    import ffd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ffd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ffd_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [63:0] cfg_data
);

    ffd_bundle_t push_bundle;
    ffd_bundle_t head_bundle;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;

    assign cfg_ready = 1'b1;

    ffd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .bundle    (push_bundle),
        .q_full    (q_full)
    );

    ffd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_bundle),
        .full  (q_full),
        .pop   (pop),
        .rdata (head_bundle),
        .empty (q_empty)
    );

    ffd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_bundle),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
